### src/wsd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and reset values for the multi-strand LED driver.
package wsd_pkg;

    localparam int MAX_STRANDS    = 3;
    localparam int STRANDS_DEF    = 3;
    localparam int PIXELS_DEF     = 8;
    localparam int BITS_PER_PIXEL = 24;
    localparam int BIT_POS_W      = 5;

    localparam int FUNC_W   = 1;
    localparam int STRAND_W = 2;
    localparam int PIXEL_W  = 3;
    localparam int BYTE_W   = 8;
    localparam int PIX_DATA_W = 3 * BYTE_W;
    localparam int MASK_W   = 3;

    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  ZERO_HIGH_RST = 8'd20;
    localparam logic [7:0]  ONE_HIGH_RST  = 8'd40;
    localparam logic [7:0]  PERIOD_RST    = 8'd63;
    localparam logic [15:0] LATCH_RST     = 16'd2500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_HIGH = 2'd0,
        CFG_ONE_HIGH  = 2'd1,
        CFG_PERIOD    = 2'd2,
        CFG_LATCH     = 2'd3
    } t_cfg_idx;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 1'b0,
        FUNC_WRITE = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_SEND  = 3'b010,
        PH_LATCH = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0]  zero_high;
        logic [7:0]  one_high;
        logic [7:0]  period;
        logic [15:0] latch;
    } t_cfg;

    // per-strand control from the top level
    typedef struct packed {
        logic tick;  // one time tick
        logic wr;    // pixel write to this strand
        logic clr;   // clearing-pass write of zero
    } t_strand_ctl;

    // per-strand status for the word being processed
    typedef struct packed {
        logic level;
        logic busy;
        logic done;
    } t_strand_sts;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [STRAND_W-1:0] strand;
        logic [PIXEL_W-1:0]  pixel;
        logic [BYTE_W-1:0]   first_byte;
        logic [BYTE_W-1:0]   second_byte;
        logic [BYTE_W-1:0]   third_byte;
    } t_in_word;

    typedef struct packed {
        logic [MASK_W-1:0] line_levels;
        logic [MASK_W-1:0] busy_mask;
        logic [MASK_W-1:0] done_mask;
    } t_out_word;

endpackage

### src/wsd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input words and result words.
interface wsd_in_if;
    logic                           valid;
    logic                           ready;
    logic [wsd_pkg::FUNC_W-1:0]     func;
    logic [wsd_pkg::STRAND_W-1:0]   strand;
    logic [wsd_pkg::PIXEL_W-1:0]    pixel;
    logic [wsd_pkg::BYTE_W-1:0]     first_byte;
    logic [wsd_pkg::BYTE_W-1:0]     second_byte;
    logic [wsd_pkg::BYTE_W-1:0]     third_byte;

    modport source (output valid, func, strand, pixel, first_byte, second_byte, third_byte,
                    input ready);
    modport sink   (input valid, func, strand, pixel, first_byte, second_byte, third_byte,
                    output ready);
endinterface

interface wsd_out_if;
    logic                           valid;
    logic                           ready;
    logic [wsd_pkg::MASK_W-1:0]     line_levels;
    logic [wsd_pkg::MASK_W-1:0]     busy_mask;
    logic [wsd_pkg::MASK_W-1:0]     done_mask;

    modport source (output valid, line_levels, busy_mask, done_mask, input ready);
    modport sink   (input valid, line_levels, busy_mask, done_mask, output ready);
endinterface

### src/wsd_strand.sv
`timescale 1ns / 1ps
// One strand: pixel memory, bit/pixel sequencing and pulse timing.
module wsd_strand #(
    parameter int PIXELS = wsd_pkg::PIXELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wsd_pkg::t_cfg                  i_cfg,
    input  wsd_pkg::t_strand_ctl           i_ctl,
    input  logic [$clog2(PIXELS)-1:0]      i_addr,
    input  logic [wsd_pkg::PIX_DATA_W-1:0] i_data,
    output wsd_pkg::t_strand_sts           o_sts
);
    localparam int PW = $clog2(PIXELS);
    localparam logic [PW-1:0] LAST_PIX = PW'(PIXELS - 1);
    localparam logic [wsd_pkg::BIT_POS_W-1:0] LAST_BIT =
        wsd_pkg::BIT_POS_W'(wsd_pkg::BITS_PER_PIXEL - 1);

    logic [wsd_pkg::PIX_DATA_W-1:0] mem [PIXELS];
    logic [wsd_pkg::PIX_DATA_W-1:0] r_rd;

    wsd_pkg::t_phase                r_phase, n_phase;
    logic [PW-1:0]                  r_pos, n_pos;
    logic [wsd_pkg::BIT_POS_W-1:0]  r_bitpos, n_bitpos;
    logic [wsd_pkg::TICK_W-1:0]     r_tick, n_tick;
    logic                           r_resend, n_resend;

    logic                           cur_bit;
    logic [7:0]                     high;
    logic [7:0]                     period;
    logic [wsd_pkg::TICK_W-1:0]     latch;
    logic [wsd_pkg::TICK_W:0]       tick_inc;
    logic                           mem_we;
    logic                           level;
    logic                           done;

    assign cur_bit  = r_rd[LAST_BIT - r_bitpos];
    assign high     = cur_bit ? i_cfg.one_high : i_cfg.zero_high;
    assign period   = (i_cfg.period == 8'd0) ? 8'd1 : i_cfg.period;
    assign latch    = (i_cfg.latch == 16'd0) ? 16'd1 : i_cfg.latch;
    assign tick_inc = {1'b0, r_tick} + 17'd1;
    assign mem_we   = i_ctl.wr | i_ctl.clr;

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_bitpos = r_bitpos;
        n_tick   = r_tick;
        n_resend = r_resend;
        level    = 1'b0;
        done     = 1'b0;
        if (i_ctl.wr) begin
            if (r_phase == wsd_pkg::PH_IDLE) begin
                n_phase  = wsd_pkg::PH_SEND;
                n_pos    = '0;
                n_bitpos = '0;
                n_tick   = '0;
            end else begin
                n_resend = 1'b1;
            end
        end else if (i_ctl.tick) begin
            unique case (r_phase)
                wsd_pkg::PH_SEND: begin
                    level  = (r_tick < {8'd0, high});
                    n_tick = tick_inc[wsd_pkg::TICK_W-1:0];
                    if (tick_inc >= {9'd0, period}) begin
                        n_tick = '0;
                        if (r_bitpos == LAST_BIT) begin
                            n_bitpos = '0;
                            if (r_pos == LAST_PIX) begin
                                n_pos   = '0;
                                n_phase = wsd_pkg::PH_LATCH;
                            end else begin
                                n_pos = r_pos + PW'(1);
                            end
                        end else begin
                            n_bitpos = r_bitpos + wsd_pkg::BIT_POS_W'(1);
                        end
                    end
                end
                wsd_pkg::PH_LATCH: begin
                    n_tick = tick_inc[wsd_pkg::TICK_W-1:0];
                    if (tick_inc >= {1'b0, latch}) begin
                        done   = 1'b1;
                        n_tick = '0;
                        if (r_resend) begin
                            n_resend = 1'b0;
                            n_phase  = wsd_pkg::PH_SEND;
                            n_pos    = '0;
                            n_bitpos = '0;
                        end else begin
                            n_phase = wsd_pkg::PH_IDLE;
                        end
                    end
                end
                wsd_pkg::PH_IDLE: begin
                    n_phase = wsd_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = wsd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    assign o_sts.level = level;
    assign o_sts.busy  = (n_phase != wsd_pkg::PH_IDLE);
    assign o_sts.done  = done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsd_pkg::PH_IDLE;
            r_pos    <= '0;
            r_bitpos <= '0;
            r_tick   <= '0;
            r_resend <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_bitpos <= n_bitpos;
            r_tick   <= n_tick;
            r_resend <= n_resend;
        end
    end

    // pixel memory; read data tracks the next pixel position, with write bypass
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[i_addr] <= i_data;
        end
        if (mem_we && (i_addr == n_pos)) begin
            r_rd <= i_data;
        end else begin
            r_rd <= mem[n_pos];
        end
    end

`ifndef ASSERT_OFF
    a_done_from_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sts.done |-> (i_ctl.tick && r_phase == wsd_pkg::PH_LATCH))
        else $error("strand done outside latch phase");
    a_bitpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bitpos <= LAST_BIT)
        else $error("bit position past last bit");
    a_send_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == wsd_pkg::PH_SEND) |-> (r_tick < 16'd255))
        else $error("send tick count past bit period");
`endif

endmodule

### src/ws2812_multi_strand_driver_core.sv
`timescale 1ns / 1ps
// Top level of the multi-strand single-wire LED driver.
//
//  channel   | dir | handshake           | word contents
//  ----------+-----+---------------------+------------------------------------------
//  i_word    | in  | valid/ready         | func, strand, pixel, three colour bytes
//  o_result  | out | valid/ready         | line_levels, busy_mask, done_mask
//  i_cfg_*   | in  | write enable only   | register index, 16-bit data
//
//  One word per cycle while results drain: a word sits in the input register, the strand
//  sequencers step it, and its result lands in the output register.
//  The output register is loaded when the word is stepped and stays valid until taken.
//  After reset a clearing pass zeroes every pixel of the pixel memories;
//  i_word.ready stays low during it, config writes are taken as usual.
//  A stalled result holds the output register; the input register still takes
//  a word if it is empty, then ready drops until the result drains.
module ws2812_multi_strand_driver_core #(
    parameter int STRANDS = wsd_pkg::STRANDS_DEF,
    parameter int PIXELS  = wsd_pkg::PIXELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    wsd_in_if.sink                         i_word,
    wsd_out_if.source                      o_result,
    input  logic                           i_cfg_we,
    input  logic [wsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wsd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int PW = $clog2(PIXELS);
    localparam logic [PW-1:0] LAST_PIX = PW'(PIXELS - 1);

    // config registers
    wsd_pkg::t_cfg     r_cfg;

    // clearing pass after reset
    logic              r_clearing;
    logic [PW-1:0]     r_clr_cnt;

    // input register
    logic              r_in_vld;
    wsd_pkg::t_in_word r_in;

    // result register
    logic               r_out_vld;
    wsd_pkg::t_out_word r_out;
    wsd_pkg::t_out_word n_out;

    logic              fire;
    logic              in_take;
    logic              is_write;
    logic              pix_ok;
    logic [PW-1:0]     mem_addr;
    logic [wsd_pkg::PIX_DATA_W-1:0] mem_data;

    wsd_pkg::t_strand_ctl ctl [wsd_pkg::MAX_STRANDS];
    wsd_pkg::t_strand_sts sts [wsd_pkg::MAX_STRANDS];

    // the word in the input register is stepped when the result slot is free
    assign fire     = r_in_vld && (!r_out_vld || o_result.ready);
    assign in_take  = i_word.valid && i_word.ready;
    assign is_write = (r_in.func == wsd_pkg::FUNC_WRITE);
    assign pix_ok   = (32'(r_in.pixel) < 32'(PIXELS));

    assign i_word.ready = !r_clearing && (!r_in_vld || fire);

    // clearing pass and pixel writes share the memory write port
    assign mem_addr = r_clearing ? r_clr_cnt : PW'(r_in.pixel);
    assign mem_data = r_clearing ? '0 : {r_in.first_byte, r_in.second_byte, r_in.third_byte};

    genvar s;
    generate
        for (s = 0; s < wsd_pkg::MAX_STRANDS; s++) begin : g_strand
            if (s < STRANDS) begin : g_on
                assign ctl[s].tick = fire && !is_write;
                assign ctl[s].wr   = fire && is_write && pix_ok &&
                                     (r_in.strand == wsd_pkg::STRAND_W'(s));
                assign ctl[s].clr  = r_clearing;

                wsd_strand #(
                    .PIXELS (PIXELS)
                ) u_strand (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_cfg   (r_cfg),
                    .i_ctl   (ctl[s]),
                    .i_addr  (mem_addr),
                    .i_data  (mem_data),
                    .o_sts   (sts[s])
                );
            end else begin : g_off
                assign ctl[s] = '0;
                assign sts[s] = '0;
            end
        end
    endgenerate

    always_comb begin
        for (int k = 0; k < wsd_pkg::MAX_STRANDS; k++) begin
            n_out.line_levels[k] = sts[k].level;
            n_out.busy_mask[k]   = sts[k].busy;
            n_out.done_mask[k]   = sts[k].done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_high <= wsd_pkg::ZERO_HIGH_RST;
            r_cfg.one_high  <= wsd_pkg::ONE_HIGH_RST;
            r_cfg.period    <= wsd_pkg::PERIOD_RST;
            r_cfg.latch     <= wsd_pkg::LATCH_RST;
        end else if (i_cfg_we) begin
            unique case (wsd_pkg::t_cfg_idx'(i_cfg_idx))
                wsd_pkg::CFG_ZERO_HIGH: r_cfg.zero_high <= i_cfg_data[7:0];
                wsd_pkg::CFG_ONE_HIGH:  r_cfg.one_high  <= i_cfg_data[7:0];
                wsd_pkg::CFG_PERIOD:    r_cfg.period    <= i_cfg_data[7:0];
                wsd_pkg::CFG_LATCH:     r_cfg.latch     <= i_cfg_data;
                default:                r_cfg           <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            if (r_clr_cnt == LAST_PIX) begin
                r_clearing <= 1'b0;
            end
            r_clr_cnt <= r_clr_cnt + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.func        <= i_word.func;
            r_in.strand      <= i_word.strand;
            r_in.pixel       <= i_word.pixel;
            r_in.first_byte  <= i_word.first_byte;
            r_in.second_byte <= i_word.second_byte;
            r_in.third_byte  <= i_word.third_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid       = r_out_vld;
    assign o_result.line_levels = r_out.line_levels;
    assign o_result.busy_mask   = r_out.busy_mask;
    assign o_result.done_mask   = r_out.done_mask;

`ifndef ASSERT_OFF
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_word.ready)
        else $error("word accepted during clearing pass");
    a_fire_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_vld)
        else $error("stepped word left no result");
    a_no_fire_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_in_vld)
        else $error("word held in input register during clearing pass");
`endif

endmodule
